// ----- rtl/core/xor_pixel_buffer_with_fade_unit_assert.svh -----
// assertion macros used by the checker of the pixel buffer
`ifndef XOR_PIXEL_BUFFER_WITH_FADE_UNIT_ASSERT_SVH
`define XOR_PIXEL_BUFFER_WITH_FADE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define XPBF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define XPBF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/xpbf_pkg.sv -----
`default_nettype none

package xpbf_pkg;

    localparam int DEF_SCREEN_W   = 64;
    localparam int DEF_SCREEN_H   = 32;
    localparam int DEF_FADE_TICKS = 1;

    localparam int KIND_W     = 2;
    localparam int COL_W      = 6;
    localparam int ROW_W      = 5;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    // operation codes, equal to the kind field values
    localparam logic [KIND_W-1:0] OP_TOGGLE = 2'd0;
    localparam logic [KIND_W-1:0] OP_TICK   = 2'd1;
    localparam logic [KIND_W-1:0] OP_READ   = 2'd2;
    localparam logic [KIND_W-1:0] OP_NONE   = 2'd3;

    typedef struct packed {
        logic we;
        logic was_on;
        logic shown;
    } t_alu_res;

endpackage

`default_nettype wire

// ----- rtl/core/xpbf_pix_ram.sv -----
`default_nettype none

module xpbf_pix_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 3,
    parameter int AW    = 11
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/xpbf_pix_alu.sv -----
`default_nettype none

module xpbf_pix_alu #(
    parameter int FADE_TICKS = 1,
    parameter int TW         = 1,
    parameter int EW         = 3
) (
    input  wire logic [xpbf_pkg::KIND_W-1:0] i_op,
    input  wire logic [EW-1:0]               i_entry,
    output logic      [EW-1:0]               o_entry,
    output xpbf_pkg::t_alu_res               o_res
);

    import xpbf_pkg::*;

    // entry layout: [0] on, [1] visible, [EW-1:2] fade timer
    logic          w_on;
    logic          w_vis;
    logic [TW-1:0] w_tmr;
    logic          w_on_n;
    logic          w_vis_n;
    logic [TW-1:0] w_tmr_n;

    assign w_on  = i_entry[0];
    assign w_vis = i_entry[1];
    assign w_tmr = i_entry[EW-1:2];

    always_comb begin
        w_on_n  = w_on;
        w_vis_n = w_vis;
        w_tmr_n = w_tmr;
        o_res   = '0;
        case (i_op)
            OP_TOGGLE: begin
                if (!w_on) begin
                    w_on_n  = 1'b1;
                    w_vis_n = 1'b1;
                end else begin
                    w_on_n  = 1'b0;
                    w_tmr_n = TW'(FADE_TICKS);
                end
                o_res.we     = 1'b1;
                o_res.was_on = w_on;
                o_res.shown  = w_vis_n;
            end
            OP_TICK: begin
                if (w_tmr != '0) begin
                    w_tmr_n = TW'(w_tmr - TW'(1));
                end else if (!w_on) begin
                    w_vis_n = 1'b0;
                end
                o_res.we = 1'b1;
            end
            OP_READ: begin
                o_res.was_on = w_on;
                o_res.shown  = w_vis;
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

    assign o_entry = {w_tmr_n, w_vis_n, w_on_n};

endmodule

`default_nettype wire

// ----- rtl/core/xor_pixel_buffer_with_fade_unit.sv -----
`default_nettype none

// Monochrome XOR pixel buffer with fade-out. Each pixel is held as one word
// (on bit, visible bit, fade timer) in a single pixel memory and is updated by
// one read-modify-write unit under a small sequencer. After reset a clearing
// pass over all SCREEN_W*SCREEN_H pixels zeroes the memory; tready stays low
// meanwhile. A toggle or read does a memory read, then the update and
// result; a tick walks every pixel one per cycle through the single memory port.
// Input tready is low while an item is in work; a finished result waits in the
// output register while the next item is taken. Off-screen toggles and reads,
// and unused kind codes, change nothing and return zeros.
module xor_pixel_buffer_with_fade_unit #(
    parameter int SCREEN_W   = xpbf_pkg::DEF_SCREEN_W,
    parameter int SCREEN_H   = xpbf_pkg::DEF_SCREEN_H,
    parameter int FADE_TICKS = xpbf_pkg::DEF_FADE_TICKS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [xpbf_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,  // col, row
    input  wire logic [xpbf_pkg::KIND_W-1:0]     i_s_axis_tuser,  // kind
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    output logic      [xpbf_pkg::OUT_DATA_W-1:0] o_m_axis_tdata   // was_on, shown
);

    import xpbf_pkg::*;

    localparam int PIX  = SCREEN_W * SCREEN_H;
    localparam int IW   = (PIX > 1) ? $clog2(PIX) : 1;
    localparam int TW   = (FADE_TICKS > 1) ? $clog2(FADE_TICKS + 1) : 1;
    localparam int EW   = TW + 2;
    localparam int LW   = IW + COL_W + ROW_W + 9;
    localparam logic [IW-1:0] LAST = IW'(PIX - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_BUSY  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [IW-1:0]     r_idx, n_idx;
    logic [KIND_W-1:0] r_op, n_op;
    logic              r_out_valid, n_out_valid;
    logic              r_was_on, n_was_on;
    logic              r_shown, n_shown;

    logic [COL_W-1:0]  w_col;
    logic [ROW_W-1:0]  w_row;
    logic [LW-1:0]     w_lin;
    logic              w_inside;
    logic [KIND_W-1:0] w_op_in;
    logic              w_accept;
    logic              w_out_free;

    logic              w_we;
    logic [IW-1:0]     w_waddr;
    logic [EW-1:0]     w_wdata;
    logic              w_re;
    logic [IW-1:0]     w_raddr;
    logic [EW-1:0]     w_rdata;
    logic [EW-1:0]     w_upd;
    t_alu_res          w_res;

    assign w_col    = i_s_axis_tdata[COL_W-1:0];
    assign w_row    = i_s_axis_tdata[COL_W+ROW_W-1:COL_W];
    assign w_lin    = LW'(w_row) * LW'(SCREEN_W) + LW'(w_col);
    assign w_inside = (32'(w_col) < 32'(SCREEN_W)) && (32'(w_row) < 32'(SCREEN_H));

    always_comb begin
        case (i_s_axis_tuser)
            OP_TOGGLE: w_op_in = w_inside ? OP_TOGGLE : OP_NONE;
            OP_TICK:   w_op_in = OP_TICK;
            OP_READ:   w_op_in = w_inside ? OP_READ : OP_NONE;
            default:   w_op_in = OP_NONE;
        endcase
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    xpbf_pix_ram #(
        .DEPTH (PIX),
        .WIDTH (EW),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    xpbf_pix_alu #(
        .FADE_TICKS (FADE_TICKS),
        .TW         (TW),
        .EW         (EW)
    ) u_alu (
        .i_op    (r_op),
        .i_entry (w_rdata),
        .o_entry (w_upd),
        .o_res   (w_res)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_op        = r_op;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_was_on    = r_was_on;
        n_shown     = r_shown;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = w_upd;
        w_re        = 1'b0;
        w_raddr     = r_idx;
        case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_wdata = '0;
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_op    = w_op_in;
                    n_idx   = (w_op_in == OP_TICK) ? '0 : w_lin[IW-1:0];
                    w_re    = 1'b1;
                    w_raddr = n_idx;
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (r_op == OP_TICK && r_idx != LAST) begin
                    w_we    = w_res.we;
                    w_re    = 1'b1;
                    w_raddr = r_idx + IW'(1);
                    n_idx   = r_idx + IW'(1);
                end else if (w_out_free) begin
                    w_we        = w_res.we;
                    n_out_valid = 1'b1;
                    n_was_on    = w_res.was_on;
                    n_shown     = w_res.shown;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_was_on <= n_was_on;
        r_shown  <= n_shown;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - 2){1'b0}}, r_shown, r_was_on};

endmodule

`default_nettype wire

// ----- rtl/core/xpbf_chk.sv -----
`default_nettype none

`include "xor_pixel_buffer_with_fade_unit_assert.svh"

module xpbf_chk (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_s_axis_tvalid,
    input wire logic                            o_s_axis_tready,
    input wire logic [xpbf_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    input wire logic [xpbf_pkg::KIND_W-1:0]     i_s_axis_tuser,
    input wire logic                            o_m_axis_tvalid,
    input wire logic                            i_m_axis_tready,
    input wire logic [xpbf_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    import xpbf_pkg::*;

    logic w_in_acc;
    logic w_stall;
    logic w_out_on;
    logic w_quiet;

    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_stall  = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_out_on = o_m_axis_tvalid && o_m_axis_tdata[0];
    assign w_quiet  = !o_m_axis_tvalid && o_s_axis_tready && !i_s_axis_tvalid;

    // a word held back keeps its valid
    `XPBF_ASSERT_NEXT(a_out_hold, w_stall, o_m_axis_tvalid, "result word dropped while stalled")

    // an item in work blocks the input in the cycle after it is taken
    `XPBF_ASSERT_NEXT(a_busy_after_acc, w_in_acc, !o_s_axis_tready, "input taken twice in a row")

    // an on pixel is always visible
    `XPBF_ASSERT_NOW(a_on_shown, w_out_on, o_m_axis_tdata[1], "on pixel reported hidden")

    // a result never appears without an item taken before it
    `XPBF_ASSERT_NEXT(a_no_spurious, w_quiet, !o_m_axis_tvalid, "result word without an item")

endmodule

bind xor_pixel_buffer_with_fade_unit xpbf_chk u_xpbf_chk (.*);

`default_nettype wire

// ----- tb/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xpbf_pkg::*;

    localparam int PIXELS          = DEF_SCREEN_W * DEF_SCREEN_H;
    localparam int RANDOM_WORDS    = 1530;
    localparam int HOLD_CYCLES     = 80;
    localparam int WATCHDOG_CYCLES = 8 * (PIXELS + 64);
    localparam int SETTLE_CYCLES   = 64;
    localparam int PLAN_LEN        = 24;

    typedef struct packed {
        logic was_on;
        logic shown;
    } pix_result_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              typed;
        logic              was_on;
        logic              shown;
    } plan_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid;
    logic [IN_DATA_W-1:0]  in_data;
    logic [KIND_W-1:0]     in_kind;
    logic                  out_ready;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    // shadow copy of the screen
    bit          pix_on   [PIXELS];
    bit          pix_vis  [PIXELS];
    int unsigned pix_fade [PIXELS];

    pix_result_t expected_pixels [$];

    int  err_count;
    int  checked_count;
    int  idle_cycles;
    int  n_toggle;
    int  n_tick;
    int  n_read;
    int  n_unused;
    bit  hold_request;

    // directed words; typed rows carry their own expected word
    plan_row_t plan [PLAN_LEN] = '{
        '{OP_READ,   6'd0,  5'd0,  1'b1, 1'b0, 1'b0},
        '{OP_READ,   6'd63, 5'd31, 1'b1, 1'b0, 1'b0},
        '{OP_TOGGLE, 6'd0,  5'd0,  1'b1, 1'b0, 1'b1},
        '{OP_TOGGLE, 6'd63, 5'd31, 1'b1, 1'b0, 1'b1},
        '{OP_READ,   6'd0,  5'd0,  1'b1, 1'b1, 1'b1},
        '{OP_TOGGLE, 6'd0,  5'd0,  1'b0, 1'b0, 1'b0},
        '{OP_TICK,   6'd0,  5'd0,  1'b1, 1'b0, 1'b0},
        '{OP_READ,   6'd0,  5'd0,  1'b0, 1'b0, 1'b0},
        '{OP_TOGGLE, 6'd63, 5'd31, 1'b0, 1'b0, 1'b0},
        '{OP_TICK,   6'd0,  5'd0,  1'b1, 1'b0, 1'b0},
        '{OP_READ,   6'd0,  5'd0,  1'b0, 1'b0, 1'b0},
        '{OP_READ,   6'd63, 5'd31, 1'b0, 1'b0, 1'b0},
        '{OP_TICK,   6'd0,  5'd0,  1'b1, 1'b0, 1'b0},
        '{OP_READ,   6'd63, 5'd31, 1'b0, 1'b0, 1'b0},
        '{OP_TOGGLE, 6'd42, 5'd21, 1'b0, 1'b0, 1'b0},
        '{OP_TOGGLE, 6'd42, 5'd21, 1'b0, 1'b0, 1'b0},
        '{OP_TOGGLE, 6'd42, 5'd21, 1'b0, 1'b0, 1'b0},
        '{OP_TICK,   6'd0,  5'd0,  1'b1, 1'b0, 1'b0},
        '{OP_READ,   6'd42, 5'd21, 1'b0, 1'b0, 1'b0},
        '{OP_TICK,   6'd0,  5'd0,  1'b1, 1'b0, 1'b0},
        '{OP_READ,   6'd42, 5'd21, 1'b0, 1'b0, 1'b0},
        '{OP_NONE,   6'd63, 5'd31, 1'b1, 1'b0, 1'b0},
        '{OP_NONE,   6'd0,  5'd0,  1'b1, 1'b0, 1'b0},
        '{OP_READ,   6'd21, 5'd10, 1'b0, 1'b0, 1'b0}
    };

    xor_pixel_buffer_with_fade_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (in_data),          // col, row
        .i_s_axis_tuser  (in_kind),          // kind
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)    // was_on, shown
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic pix_result_t apply_pixel_op(input logic [KIND_W-1:0] kind,
                                                   input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] row);
        pix_result_t r;
        int idx;
        bit on_screen;
        r = '0;
        on_screen = (int'(col) < DEF_SCREEN_W) && (int'(row) < DEF_SCREEN_H);
        idx = int'(row) * DEF_SCREEN_W + int'(col);
        case (kind)
            OP_TOGGLE: begin
                if (on_screen) begin
                    r.was_on = pix_on[idx];
                    if (!pix_on[idx]) begin
                        pix_on[idx]  = 1'b1;
                        pix_vis[idx] = 1'b1;
                    end else begin
                        pix_on[idx]   = 1'b0;
                        pix_fade[idx] = DEF_FADE_TICKS & 255;
                    end
                    r.shown = pix_vis[idx];
                end
            end
            OP_TICK: begin
                for (int i = 0; i < PIXELS; i++) begin
                    if (pix_fade[i] != 0)
                        pix_fade[i] = pix_fade[i] - 1;
                    else if (!pix_on[i])
                        pix_vis[i] = 1'b0;
                end
            end
            OP_READ: begin
                if (on_screen) begin
                    r.was_on = pix_on[idx];
                    r.shown  = pix_vis[idx];
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [COL_W-1:0] col,
                             input logic [ROW_W-1:0] row, input bit typed,
                             input pix_result_t fixed, input int gap);
        pix_result_t predicted;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_kind  <= kind;
        in_data  <= {{(IN_DATA_W-COL_W-ROW_W){1'b0}}, row, col};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = apply_pixel_op(kind, col, row);
        expected_pixels.push_back(typed ? fixed : predicted);
        case (kind)
            OP_TOGGLE: n_toggle++;
            OP_TICK:   n_tick++;
            OP_READ:   n_read++;
            default:   n_unused++;
        endcase
        @(negedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        pix_result_t want;
        if (i_rst_n && o_m_axis_tvalid && out_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected word: was_on %0d shown %0d",
                       o_m_axis_tdata[0], o_m_axis_tdata[1]);
                err_count++;
            end else begin
                want = expected_pixels.pop_front();
                checked_count++;
                if (o_m_axis_tdata[0] !== want.was_on) begin
                    $error("was_on mismatch: expected %0d, got %0d",
                           want.was_on, o_m_axis_tdata[0]);
                    err_count++;
                end
                if (o_m_axis_tdata[1] !== want.shown) begin
                    $error("shown mismatch: expected %0d, got %0d",
                           want.shown, o_m_axis_tdata[1]);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_s_axis_tready) || (o_m_axis_tvalid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("watchdog expired with %0d words outstanding",
                         expected_pixels.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // receiver
    initial begin
        int stall;
        bit burst;
        out_ready = 1'b0;
        burst = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                burst = !burst;
            stall = burst ? 0 : $urandom_range(0, 12);
            if (hold_request) begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    initial begin
        int words;
        int gap;
        int pick;
        int pressure_left;
        bit burst;
        bit typed;
        logic [KIND_W-1:0] kind;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        pix_result_t fixed;

        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        in_kind = OP_TOGGLE;
        hold_request = 1'b0;
        err_count = 0;
        checked_count = 0;
        idle_cycles = 0;
        n_toggle = 0;
        n_tick = 0;
        n_read = 0;
        n_unused = 0;
        burst = 1'b0;
        pressure_left = 0;
        foreach (pix_on[i]) begin
            pix_on[i] = 1'b0;
            pix_vis[i] = 1'b0;
            pix_fade[i] = 0;
        end

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < PLAN_LEN; i++) begin
            fixed.was_on = plan[i].was_on;
            fixed.shown  = plan[i].shown;
            send_word(plan[i].kind, plan[i].col, plan[i].row, plan[i].typed, fixed,
                      $urandom_range(0, 12));
        end

        words = 0;
        while (words < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 48)
                kind = OP_TOGGLE;
            else if (pick < 93)
                kind = OP_READ;
            else if (pick < 97)
                kind = OP_TICK;
            else
                kind = OP_NONE;
            // mostly a few pixels in each corner so toggles and fades pile up
            if ($urandom_range(0, 4) != 0) begin
                col = $urandom_range(0, 3);
                row = $urandom_range(0, 1);
                if ($urandom_range(0, 1))
                    col = DEF_SCREEN_W - 1 - col;
                if ($urandom_range(0, 1))
                    row = DEF_SCREEN_H - 1 - row;
            end else begin
                col = $urandom_range(0, DEF_SCREEN_W - 1);
                row = $urandom_range(0, DEF_SCREEN_H - 1);
            end
            if (words == RANDOM_WORDS / 2 && pressure_left == 0) begin
                hold_request = 1'b1;
                pressure_left = 40;
            end
            if ($urandom_range(0, 39) == 0)
                burst = !burst;
            if (pressure_left > 0) begin
                gap = 0;
                pressure_left--;
            end else begin
                gap = burst ? 0 : $urandom_range(0, 12);
            end
            typed = 1'b0;
            fixed = '0;
            send_word(kind, col, row, typed, fixed, gap);
            words++;
        end
        in_valid <= 1'b0;

        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d toggles, %0d reads, %0d ticks and %0d unused kinds",
                 n_toggle, n_read, n_tick, n_unused);
        $display("%0d words checked, including a %0d cycle receiver hold-off",
                 checked_count, HOLD_CYCLES);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/xpbf_pkg.sv
rtl/core/xpbf_pix_ram.sv
rtl/core/xpbf_pix_alu.sv
rtl/core/xor_pixel_buffer_with_fade_unit.sv
rtl/core/xpbf_chk.sv
tb/tb.sv
